[rtl/vertex_dedup_indexer_unit_assert.svh]
// Assertion macros for the vertex dedup indexer
`ifndef VERTEX_DEDUP_INDEXER_UNIT_ASSERT_SVH
`define VERTEX_DEDUP_INDEXER_UNIT_ASSERT_SVH

`ifndef SYNTH

`define VDI_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vdi: implication check failed");

`define VDI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vdi: next-cycle check failed");

`else

`define VDI_ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`define VDI_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[rtl/vdi_pkg.sv]
// Shared constants for the vertex dedup indexer
`default_nettype none

package vdi_pkg;

    localparam int MAX_VERTS = 1024;
    localparam int ADDR_W    = $clog2(MAX_VERTS);
    localparam int CNT_W     = $clog2(MAX_VERTS + 1);
    localparam int FIELD_W   = 32;
    localparam int INDEX_W   = 10;
    localparam int WORD_W    = 8 * FIELD_W;

endpackage

`default_nettype wire

[rtl/vdi_vertex_if.sv]
// Handshake channels: vertex input and index result
`default_nettype none

interface vdi_vertex_if;
    import vdi_pkg::*;

    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] tex_u;
    logic [FIELD_W-1:0] tex_v;
    logic [FIELD_W-1:0] norm_x;
    logic [FIELD_W-1:0] norm_y;
    logic [FIELD_W-1:0] norm_z;
    logic [FIELD_W-1:0] pos_x;
    logic [FIELD_W-1:0] pos_y;
    logic [FIELD_W-1:0] pos_z;

    modport source (output valid, tex_u, tex_v, norm_x, norm_y, norm_z, pos_x, pos_y, pos_z,
                    input ready);
    modport sink   (input valid, tex_u, tex_v, norm_x, norm_y, norm_z, pos_x, pos_y, pos_z,
                    output ready);
endinterface

interface vdi_result_if;
    import vdi_pkg::*;

    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] vertex_index;
    logic               is_new;
    logic               overflow;

    modport source (output valid, vertex_index, is_new, overflow, input ready);
    modport sink   (input valid, vertex_index, is_new, overflow, output ready);
endinterface

`default_nettype wire

[rtl/vertex_dedup_indexer_unit.sv]
// Vertex dedup indexer: linear search of a vertex table held in one synchronous RAM
//
// Each accepted vertex is compared against the stored table, one entry per cycle through the
// single read port of the vertex RAM, starting at entry 0; the first bitwise match returns its
// index. With no match the vertex is appended at the next free entry (is_new = 1), or, if the
// table already holds MAX_VERTS entries, the result reports overflow with index 0. With
// use_normals = 0 the normal fields are left out of the compare and stored as zero. The time
// from transfer to result is set by the scan through the RAM read port: a miss scans every
// stored entry, a hit at entry i stops there. The unit passes through idle before the next
// vertex can be taken, and the result stage stalls while the output register still holds an
// unaccepted result.
// One item is in work at a time; the next vertex is taken while the previous result still
// waits in the output register. The table needs no clearing pass: only entries below the
// vertex count are ever read.
`default_nettype none

module vertex_dedup_indexer_unit (
    input  wire logic clk,
    input  wire logic rst_n,
    vdi_vertex_if.sink     vertex,
    vdi_result_if.source   result,
    input  wire logic cfg_we,
    input  wire logic cfg_wdata
);
    import vdi_pkg::*;

`include "vertex_dedup_indexer_unit_assert.svh"

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_RESULT
    } state_t;

    state_t              state_reg, state_next;
    logic                use_normals_reg, use_normals_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    scan_addr_reg, scan_addr_next;
    logic                rd_valid_reg, rd_valid_next;
    logic [ADDR_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [ADDR_W-1:0]   res_idx_reg, res_idx_next;
    logic                res_new_reg, res_new_next;
    logic                res_ovf_reg, res_ovf_next;
    logic                out_valid_reg, out_valid_next;
    logic [INDEX_W-1:0]  out_idx_reg, out_idx_next;
    logic                out_new_reg, out_new_next;
    logic                out_ovf_reg, out_ovf_next;

    // search key, normals already zeroed when ignored
    logic [WORD_W-1:0]   key_reg;
    logic                key_norm_reg;

    logic [WORD_W-1:0]   mem [MAX_VERTS];
    logic [WORD_W-1:0]   mem_q_reg;
    logic                mem_re;
    logic [ADDR_W-1:0]   mem_raddr;
    logic                mem_we;

    logic                in_xfer;
    logic                out_free;
    logic                hit;
    logic                issue_done;
    logic                table_full;

    assign in_xfer    = vertex.valid && vertex.ready;
    assign out_free   = !out_valid_reg || result.ready;
    assign issue_done = (scan_addr_reg == count_reg);
    assign table_full = (count_reg == CNT_W'(MAX_VERTS));

    // word layout: {pos_z, pos_y, pos_x, norm_z, norm_y, norm_x, tex_v, tex_u}
    assign hit = rd_valid_reg
              && (mem_q_reg[63:0] == key_reg[63:0])
              && (mem_q_reg[255:160] == key_reg[255:160])
              && (!key_norm_reg || (mem_q_reg[159:64] == key_reg[159:64]));

    assign mem_re    = (state_reg == ST_SEARCH) && !issue_done;
    assign mem_raddr = scan_addr_reg[ADDR_W-1:0];
    assign mem_we    = (state_reg == ST_RESULT) && out_free && res_new_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[count_reg[ADDR_W-1:0]] <= key_reg;
        end
        if (mem_re)
        begin
            mem_q_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            key_norm_reg <= use_normals_reg;
            key_reg <= {vertex.pos_z, vertex.pos_y, vertex.pos_x,
                        use_normals_reg ? vertex.norm_z : '0,
                        use_normals_reg ? vertex.norm_y : '0,
                        use_normals_reg ? vertex.norm_x : '0,
                        vertex.tex_v, vertex.tex_u};
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        use_normals_next = cfg_we ? cfg_wdata : use_normals_reg;
        count_next       = count_reg;
        scan_addr_next   = scan_addr_reg;
        rd_valid_next    = 1'b0;
        rd_idx_next      = rd_idx_reg;
        res_idx_next     = res_idx_reg;
        res_new_next     = res_new_reg;
        res_ovf_next     = res_ovf_reg;
        out_valid_next   = out_valid_reg && !result.ready;
        out_idx_next     = out_idx_reg;
        out_new_next     = out_new_reg;
        out_ovf_next     = out_ovf_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    scan_addr_next = '0;
                    state_next     = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                priority if (hit)
                begin
                    res_idx_next = rd_idx_reg;
                    res_new_next = 1'b0;
                    res_ovf_next = 1'b0;
                    state_next   = ST_RESULT;
                end
                else if (issue_done && !rd_valid_reg)
                begin
                    res_idx_next = table_full ? '0 : count_reg[ADDR_W-1:0];
                    res_new_next = !table_full;
                    res_ovf_next = table_full;
                    state_next   = ST_RESULT;
                end
                else if (!issue_done)
                begin
                    rd_valid_next  = 1'b1;
                    rd_idx_next    = scan_addr_reg[ADDR_W-1:0];
                    scan_addr_next = scan_addr_reg + 1'b1;
                end
                else
                begin
                    rd_valid_next = 1'b0;
                end
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_idx_next   = INDEX_W'(res_idx_reg);
                    out_new_next   = res_new_reg;
                    out_ovf_next   = res_ovf_reg;
                    if (res_new_reg)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            use_normals_reg <= 1'b1;
            count_reg       <= '0;
            scan_addr_reg   <= '0;
            rd_valid_reg    <= 1'b0;
            rd_idx_reg      <= '0;
            res_idx_reg     <= '0;
            res_new_reg     <= 1'b0;
            res_ovf_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_idx_reg     <= '0;
            out_new_reg     <= 1'b0;
            out_ovf_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            use_normals_reg <= use_normals_next;
            count_reg       <= count_next;
            scan_addr_reg   <= scan_addr_next;
            rd_valid_reg    <= rd_valid_next;
            rd_idx_reg      <= rd_idx_next;
            res_idx_reg     <= res_idx_next;
            res_new_reg     <= res_new_next;
            res_ovf_reg     <= res_ovf_next;
            out_valid_reg   <= out_valid_next;
            out_idx_reg     <= out_idx_next;
            out_new_reg     <= out_new_next;
            out_ovf_reg     <= out_ovf_next;
        end
    end

    assign vertex.ready        = (state_reg == ST_IDLE);
    assign result.valid        = out_valid_reg;
    assign result.vertex_index = out_idx_reg;
    assign result.is_new       = out_new_reg;
    assign result.overflow     = out_ovf_reg;

    `VDI_ASSERT_IMPLY(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(MAX_VERTS))
    `VDI_ASSERT_NEXT(a_count_step, clk, rst_n, mem_we, count_reg == CNT_W'($past(count_reg) + 1'b1))
    `VDI_ASSERT_IMPLY(a_hit_in_table, clk, rst_n, hit, CNT_W'(rd_idx_reg) < count_reg)
    `VDI_ASSERT_IMPLY(a_new_xor_ovf, clk, rst_n, out_valid_reg, !(out_new_reg && out_ovf_reg))

endmodule

`default_nettype wire

[bench/tb.sv]
// Testbench for vertex_dedup_indexer_unit: directed vertex table, then random streams vs. a table model
`timescale 1ns / 1ps

module tb;
    import vdi_pkg::*;

    localparam int CYCLE_LIMIT = 6_000_000;
    localparam int TAIL_CYCLES = 1100;
    localparam int PHASE_ITEMS = 111;
    localparam int N_PHASES    = 5;
    localparam int MAX_PRINTS  = 50;

    localparam logic [FIELD_W-1:0] W0    = 32'h0000_0000;
    localparam logic [FIELD_W-1:0] W1    = 32'hffff_ffff;
    localparam logic [FIELD_W-1:0] NEG0  = 32'h8000_0000;
    localparam logic [FIELD_W-1:0] ONE_F = 32'h3f80_0000;

    typedef struct packed {
        logic [FIELD_W-1:0] tex_u;
        logic [FIELD_W-1:0] tex_v;
        logic [FIELD_W-1:0] norm_x;
        logic [FIELD_W-1:0] norm_y;
        logic [FIELD_W-1:0] norm_z;
        logic [FIELD_W-1:0] pos_x;
        logic [FIELD_W-1:0] pos_y;
        logic [FIELD_W-1:0] pos_z;
    } vtx_t;

    typedef struct packed {
        logic [INDEX_W-1:0] vertex_index;
        logic               is_new;
        logic               overflow;
    } idx_res_t;

    typedef struct packed {
        logic     use_nrm;
        vtx_t     v;
        logic     typed;
        idx_res_t res;
    } dir_row_t;

    localparam int N_DIRECTED = 23;

    // columns of v: u, v, nx, ny, nz, px, py, pz
    dir_row_t directed [N_DIRECTED] = '{
        '{1'b1, '{W0, W0, W0, W0, W0, W0, W0, W0}, 1'b1, '{10'd0, 1'b1, 1'b0}},
        '{1'b1, '{W1, W1, W1, W1, W1, W1, W1, W1}, 1'b1, '{10'd1, 1'b1, 1'b0}},
        '{1'b1, '{W0, W0, W0, W0, W0, W0, W0, W0}, 1'b1, '{10'd0, 1'b0, 1'b0}},
        '{1'b1, '{W1, W1, W1, W1, W1, W1, W1, W1}, 1'b1, '{10'd1, 1'b0, 1'b0}},
        '{1'b1, '{W1, W0, W0, W0, W0, W0, W0, W0}, 1'b0, '0},
        '{1'b1, '{W0, W1, W0, W0, W0, W0, W0, W0}, 1'b0, '0},
        '{1'b1, '{W0, W0, W1, W0, W0, W0, W0, W0}, 1'b0, '0},
        '{1'b1, '{W0, W0, W0, W1, W0, W0, W0, W0}, 1'b0, '0},
        '{1'b1, '{W0, W0, W0, W0, W1, W0, W0, W0}, 1'b0, '0},
        '{1'b1, '{W0, W0, W0, W0, W0, W1, W0, W0}, 1'b0, '0},
        '{1'b1, '{W0, W0, W0, W0, W0, W0, W1, W0}, 1'b0, '0},
        '{1'b1, '{W0, W0, W0, W0, W0, W0, W0, W1}, 1'b0, '0},
        '{1'b1, '{NEG0, W0, W0, W0, W0, W0, W0, W0}, 1'b0, '0},
        // normals ignored: stored normals must not matter for the match
        '{1'b0, '{W0, W0, W1, W1, W1, W0, W0, W0}, 1'b0, '0},
        '{1'b0, '{W1, W1, W0, W0, W0, W1, W1, W1}, 1'b0, '0},
        '{1'b0, '{ONE_F, ONE_F, W1, W1, W1, ONE_F, ONE_F, ONE_F}, 1'b0, '0},
        // back to normals on: entry above holds zero normals
        '{1'b1, '{ONE_F, ONE_F, W0, W0, W0, ONE_F, ONE_F, ONE_F}, 1'b0, '0},
        '{1'b1, '{ONE_F, ONE_F, W1, W1, W1, ONE_F, ONE_F, ONE_F}, 1'b0, '0},
        '{1'b0, '{W1, W0, NEG0, W0, W1, W0, W0, W0}, 1'b0, '0},
        // several entries match with normals ignored: first one wins
        '{1'b0, '{W0, W0, W0, W1, W0, W0, W0, W0}, 1'b0, '0},
        '{1'b1, '{W0, W0, W0, W0, W0, W0, W0, 32'h1}, 1'b0, '0},
        '{1'b1, '{W0, W0, W0, W0, W0, W0, W0, 32'h1}, 1'b0, '0},
        '{1'b1, '{W0, W0, W0, W0, W0, W0, W0, NEG0}, 1'b0, '0}
    };

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    vdi_vertex_if vin ();
    vdi_result_if rout ();

    vertex_dedup_indexer_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .vertex    (vin),
        .result    (rout),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // model of the vertex table
    vtx_t        vtx_table [MAX_VERTS];
    int unsigned vtx_count;
    bit          normals_on;

    idx_res_t index_queue [$];

    int  cycles;
    int  errors;
    int  n_sent, n_new, n_hit, n_ovf, n_cfg;
    int  stall_pct;
    bit  gap_on;
    int  burst_left;
    bit  vin_on;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     index_queue.size());
            $display("simulation failed");
            $finish;
        end
    end

    task automatic report_error(input string msg);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("ERROR cycle %0d: %s", cycles, msg);
    endtask

    function automatic idx_res_t lookup_or_append(input vtx_t v);
        vtx_t     key;
        idx_res_t r;
        bit       hit;
        key = v;
        if (!normals_on)
        begin
            key.norm_x = '0;
            key.norm_y = '0;
            key.norm_z = '0;
        end
        for (int unsigned i = 0; i < vtx_count; i++)
        begin
            hit = vtx_table[i].tex_u == key.tex_u && vtx_table[i].tex_v == key.tex_v
                && vtx_table[i].pos_x == key.pos_x && vtx_table[i].pos_y == key.pos_y
                && vtx_table[i].pos_z == key.pos_z;
            if (normals_on)
                hit = hit && vtx_table[i].norm_x == key.norm_x
                    && vtx_table[i].norm_y == key.norm_y && vtx_table[i].norm_z == key.norm_z;
            if (hit)
            begin
                r.vertex_index = i[INDEX_W-1:0];
                r.is_new = 1'b0;
                r.overflow = 1'b0;
                return r;
            end
        end
        if (vtx_count >= MAX_VERTS)
        begin
            r = '0;
            r.overflow = 1'b1;
            return r;
        end
        vtx_table[vtx_count] = key;
        r.vertex_index = vtx_count[INDEX_W-1:0];
        r.is_new = 1'b1;
        r.overflow = 1'b0;
        vtx_count++;
        return r;
    endfunction

    function automatic logic [FIELD_W-1:0] rand_word();
        case ($urandom_range(0, 11))
            0: return W0;
            1: return W1;
            2: return NEG0;
            3: return ONE_F;
            default: return $urandom;
        endcase
    endfunction

    function automatic vtx_t fresh_vertex();
        vtx_t v;
        v.tex_u  = rand_word();
        v.tex_v  = rand_word();
        v.norm_x = rand_word();
        v.norm_y = rand_word();
        v.norm_z = rand_word();
        v.pos_x  = $urandom;
        v.pos_y  = $urandom;
        v.pos_z  = $urandom;
        return v;
    endfunction

    // repeat a stored vertex; normals are free when ignored
    function automatic vtx_t replay_vertex(input int unsigned idx, input bit new_normals);
        vtx_t v;
        v = vtx_table[idx];
        if (!normals_on || new_normals)
        begin
            v.norm_x = rand_word();
            v.norm_y = rand_word();
            v.norm_z = rand_word();
        end
        return v;
    endfunction

    function automatic vtx_t mixed_vertex();
        vtx_t        v;
        int          k;
        int          b;
        int unsigned idx;
        k = $urandom_range(0, 99);
        if (vtx_count == 0 || k < 20)
            return fresh_vertex();
        idx = $urandom_range(0, vtx_count - 1);
        if (k < 70)
            return replay_vertex(idx, 1'b0);
        if (k < 90)
        begin
            v = replay_vertex(idx, 1'b0);
            b = $urandom_range(0, 8 * FIELD_W - 1);
            v[b] = ~v[b];
            return v;
        end
        return replay_vertex(idx, 1'b1);
    endfunction

    // call at a falling edge; returns at a falling edge after the transfer
    task automatic send_vertex(input vtx_t v, input bit typed, input idx_res_t typed_res);
        idx_res_t r;
        vin.valid  <= 1'b1;
        vin.tex_u  <= v.tex_u;
        vin.tex_v  <= v.tex_v;
        vin.norm_x <= v.norm_x;
        vin.norm_y <= v.norm_y;
        vin.norm_z <= v.norm_z;
        vin.pos_x  <= v.pos_x;
        vin.pos_y  <= v.pos_y;
        vin.pos_z  <= v.pos_z;
        vin_on = 1'b1;
        @(posedge clk);
        while (!(vin.valid === 1'b1 && vin.ready === 1'b1))
            @(posedge clk);
        r = lookup_or_append(v);
        index_queue.push_back(typed ? typed_res : r);
        n_sent++;
        @(negedge clk);
        if (gap_on)
        begin
            burst_left--;
            if (burst_left <= 0)
            begin
                vin.valid <= 1'b0;
                vin_on = 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge clk);
                burst_left = $urandom_range(1, 10);
            end
        end
    endtask

    task automatic drain_results();
        if (vin_on)
        begin
            vin.valid <= 1'b0;
            vin_on = 1'b0;
        end
        do
            @(posedge clk);
        while (index_queue.size() != 0);
        @(negedge clk);
    endtask

    task automatic set_normals(input bit val);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= val;
        normals_on = val;
        n_cfg++;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // result side: stalls of its own, mostly short, now and then long
    initial
    begin : sink_side
        int stall_left;
        stall_left = 0;
        rout.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                rout.ready <= 1'b0;
                stall_left--;
            end
            else if ($urandom_range(0, 99) < stall_pct)
            begin
                rout.ready <= 1'b0;
                stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 30)
                                                          : $urandom_range(0, 4);
            end
            else
                rout.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_results
        idx_res_t want;
        if (rst_n && rout.valid === 1'b1 && rout.ready === 1'b1)
        begin
            if (index_queue.size() == 0)
                report_error($sformatf("result index %0d with nothing expected",
                                       rout.vertex_index));
            else
            begin
                want = index_queue.pop_front();
                if (rout.vertex_index !== want.vertex_index)
                    report_error($sformatf("vertex_index got %0d want %0d",
                                           rout.vertex_index, want.vertex_index));
                if (rout.is_new !== want.is_new)
                    report_error($sformatf("is_new got %b want %b (index %0d)",
                                           rout.is_new, want.is_new, want.vertex_index));
                if (rout.overflow !== want.overflow)
                    report_error($sformatf("overflow got %b want %b (index %0d)",
                                           rout.overflow, want.overflow, want.vertex_index));
                if (want.overflow)
                    n_ovf++;
                else if (want.is_new)
                    n_new++;
                else
                    n_hit++;
            end
        end
    end

    initial
    begin : stimulus
        int   pause_at;
        errors = 0;
        n_sent = 0;
        n_new = 0;
        n_hit = 0;
        n_ovf = 0;
        n_cfg = 0;
        vtx_count = 0;
        normals_on = 1'b1;
        stall_pct = 0;
        gap_on = 1'b0;
        burst_left = 1;
        vin_on = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 1'b0;
        vin.valid = 1'b0;
        vin.tex_u = '0;
        vin.tex_v = '0;
        vin.norm_x = '0;
        vin.norm_y = '0;
        vin.norm_z = '0;
        vin.pos_x = '0;
        vin.pos_y = '0;
        vin.pos_z = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        set_normals(1'b1);
        stall_pct = 25;
        gap_on = 1'b1;
        burst_left = 3;
        foreach (directed[i])
        begin
            if (directed[i].use_nrm != normals_on)
                set_normals(directed[i].use_nrm);
            send_vertex(directed[i].v, directed[i].typed, directed[i].res);
        end

        // random phases, alternating the normals setting
        for (int p = 0; p < N_PHASES; p++)
        begin
            set_normals(p % 2 == 0);
            stall_pct = (p == 2) ? 0 : $urandom_range(5, 60);
            gap_on = (p != 2);
            burst_left = $urandom_range(1, 10);
            pause_at = $urandom_range(10, PHASE_ITEMS - 10);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i == pause_at)
                    drain_results();
                send_vertex(mixed_vertex(), 1'b0, '0);
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("ran %0d vertices in %0d cycles: %0d appended, %0d matched, %0d overflowed",
                 n_sent, cycles, n_new, n_hit, n_ovf);
        $display("%0d normals setting writes, %0d table entries at the end, %0d mismatches",
                 n_cfg, vtx_count, errors);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/vdi_pkg.sv
rtl/vdi_vertex_if.sv
rtl/vertex_dedup_indexer_unit.sv
bench/tb.sv
